// ===== sv/mmrb_pkg.sv =====
// Shared types, codes and defaults for the row-biased matrix multiply block.
package mmrb_pkg;

    localparam int DIM_DEFAULT          = 16;
    localparam int ELEMENT_BITS_DEFAULT = 16;

    // Field widths of the item words
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 16;
    localparam int POS_W    = 6;
    localparam int RESULT_W = 40;
    localparam int BIAS_SHIFT = 8;

    localparam logic [ACTION_W-1:0] ACT_LOAD_A    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_BIAS = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE   = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]           row;
        logic [POS_W-1:0]           col;
        logic signed [RESULT_W-1:0] result_value;
        logic                       last;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             wr_bias;
        logic             rd_bias;
        logic             mac_issue;
        logic             mac_first;
        logic             out_load;
        logic             out_last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] k;
    } t_mac_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_mac_stat;

endpackage

// ===== sv/mmrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mmrb_ctrl.sv =====
// Sequencer for loads and row computes: column and dot-product counters.
module mmrb_ctrl #(
    parameter int DIM = mmrb_pkg::DIM_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mmrb_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    input  mmrb_pkg::t_mac_stat i_stat,
    output mmrb_pkg::t_mac_cmd  o_cmd
);

    localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RUN    = 3'd1;
    localparam logic [2:0] S_DRAIN1 = 3'd2;
    localparam logic [2:0] S_DRAIN2 = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_row, n_row;
    logic [IW-1:0] r_col, n_col;
    logic [IW-1:0] r_k, n_k;

    logic accept;
    logic load_ok;
    logic row_ok;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign load_ok    = (32'(i_in_item.index) < 32'(DIM * DIM));
    assign row_ok     = (32'(i_in_item.index) < 32'(DIM));

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;

        o_cmd           = '0;
        o_cmd.row       = mmrb_pkg::POS_W'(r_row);
        o_cmd.col       = mmrb_pkg::POS_W'(r_col);
        o_cmd.k         = mmrb_pkg::POS_W'(r_k);
        o_cmd.mac_first = (r_k == '0);
        o_cmd.out_last  = (r_col == LAST_IDX);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.action)
                        mmrb_pkg::ACT_LOAD_A:    o_cmd.wr_a    = load_ok;
                        mmrb_pkg::ACT_LOAD_B:    o_cmd.wr_b    = load_ok;
                        mmrb_pkg::ACT_LOAD_BIAS: o_cmd.wr_bias = row_ok;
                        mmrb_pkg::ACT_COMPUTE: begin
                            if (row_ok) begin
                                // fetch the row's bias now, it holds for all columns
                                o_cmd.rd_bias = 1'b1;
                                n_row   = IW'(i_in_item.index);
                                n_col   = '0;
                                n_k     = '0;
                                n_state = S_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                o_cmd.mac_issue = 1'b1;
                if (r_k == LAST_IDX) begin
                    n_state = S_DRAIN1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_EMIT;
            S_EMIT: begin
                // hold the finished sum until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_k = '0;
                    if (r_col == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

endmodule

// ===== sv/mmrb_dp.sv =====
// Element stores, multiply-accumulate pipeline and output register.
module mmrb_dp #(
    parameter int DIM          = mmrb_pkg::DIM_DEFAULT,
    parameter int ELEMENT_BITS = mmrb_pkg::ELEMENT_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmrb_pkg::t_in_item  i_in_item,
    input  mmrb_pkg::t_mac_cmd  i_cmd,
    output mmrb_pkg::t_mac_stat o_stat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mmrb_pkg::t_out_item o_out_item
);

    localparam int EB  = ELEMENT_BITS;
    localparam int RW  = mmrb_pkg::RESULT_W;
    localparam int AW  = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
    localparam int BAW = (DIM > 1) ? $clog2(DIM) : 1;

    logic signed [EB-1:0] wr_elem;
    logic [AW-1:0]        wr_addr;
    logic [BAW-1:0]       bias_addr;
    logic [AW-1:0]        a_raddr;
    logic [AW-1:0]        b_raddr;
    logic [EB-1:0]        a_rdata;
    logic [EB-1:0]        b_rdata;
    logic [EB-1:0]        bias_rdata;

    logic                   r_s1_valid, r_s1_first;
    logic                   r_s2_valid, r_s2_first;
    logic signed [2*EB-1:0] r_prod;
    logic signed [RW-1:0]   r_acc;
    logic signed [RW-1:0]   prod_ext;
    logic signed [RW-1:0]   bias_ext;
    logic signed [RW-1:0]   bias_q;

    logic                r_out_valid;
    mmrb_pkg::t_out_item r_out;

    // low bits kept when narrower, sign extended when wider
    assign wr_elem   = EB'(i_in_item.value);
    assign wr_addr   = AW'(i_in_item.index);
    // the compute word's index names the row whose bias is read
    assign bias_addr = BAW'(i_in_item.index);
    assign a_raddr   = AW'(32'(i_cmd.row) * 32'(DIM) + 32'(i_cmd.k));
    assign b_raddr   = AW'(32'(i_cmd.k) * 32'(DIM) + 32'(i_cmd.col));

    mmrb_ram #(.WIDTH(EB), .DEPTH(DIM * DIM)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a),
        .i_waddr (wr_addr),
        .i_wdata (wr_elem),
        .i_re    (i_cmd.mac_issue),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mmrb_ram #(.WIDTH(EB), .DEPTH(DIM * DIM)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b),
        .i_waddr (wr_addr),
        .i_wdata (wr_elem),
        .i_re    (i_cmd.mac_issue),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mmrb_ram #(.WIDTH(EB), .DEPTH(DIM)) u_ram_bias (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_bias),
        .i_waddr (bias_addr),
        .i_wdata (wr_elem),
        .i_re    (i_cmd.rd_bias),
        .i_raddr (bias_addr),
        .o_rdata (bias_rdata)
    );

    assign prod_ext = RW'(r_prod);
    assign bias_ext = RW'($signed(bias_rdata));
    assign bias_q   = {bias_ext[RW-mmrb_pkg::BIAS_SHIFT-1:0], {mmrb_pkg::BIAS_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_first <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_first <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.mac_issue;
            r_s1_first <= i_cmd.mac_first;
            r_s2_valid <= r_s1_valid;
            r_s2_first <= r_s1_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_prod <= $signed(a_rdata) * $signed(b_rdata);
        end
        // start each column from the aligned bias, wrap modulo the result width
        if (r_s2_valid) begin
            r_acc <= (r_s2_first ? bias_q : r_acc) + prod_ext;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.row          <= i_cmd.row;
            r_out.col          <= i_cmd.col;
            r_out.result_value <= r_acc;
            r_out.last         <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sv/matrix_multiply_row_bias_top.sv =====
// Top level of the row-biased fixed-point matrix multiply block.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one word per
// accepted edge. Load words write one Q8.8 element of A, B or the bias
// vector; out-of-range loads are dropped. A compute word names a row i
// and yields DIM output words C[i][0..DIM-1] in column order on the output
// channel (o_out_valid / i_out_stall / o_out_item), each the Q24.16
// bias[i] plus the dot product of row i of A and column j of B, with last
// set on column DIM-1. An out-of-range row is dropped. One multiplier is
// shared: each column issues DIM products through the read, multiply and
// accumulate stages, then drains and hands the sum to the output register.
// The input stalls while a row is in progress. When the receiver stalls,
// the finished column is held and the sequencer waits before loading the
// next one. Reset clears the sequencer and the output valid; the element
// stores are undefined until written.
module matrix_multiply_row_bias_top #(
    parameter int DIM          = mmrb_pkg::DIM_DEFAULT,
    parameter int ELEMENT_BITS = mmrb_pkg::ELEMENT_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mmrb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mmrb_pkg::t_out_item o_out_item
);

    mmrb_pkg::t_mac_cmd  cmd;
    mmrb_pkg::t_mac_stat stat;

    mmrb_ctrl #(.DIM(DIM)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mmrb_dp #(.DIM(DIM), .ELEMENT_BITS(ELEMENT_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
